// ----- hdl/bmsm_pkg.sv -----
// bmsm_pkg: shared widths, codes, command/status types and neighbour offsets
// for the beamlet map smoothing unit; no dependencies

package bmsm_pkg;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int BEAM_W   = 3;
    localparam int COORD_W  = 5;
    localparam int ENTRY_W  = 13;
    localparam int BL_OUT_W = 12;
    localparam int FL_W     = 32;
    localparam int BCNT_W   = 13;

    // stream packing
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 1;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_MAP_WR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FL_WR  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SMOOTH = 2'd2;

    // parameter defaults
    localparam int MAP_W_DEF        = 32;
    localparam int MAP_H_DEF        = 32;
    localparam int MAX_BEAMS_DEF    = 8;
    localparam int MAX_BEAMLETS_DEF = 4096;

    // neighbour walk: centre first, then the eight neighbours row by row
    localparam int               NBR_W      = 4;
    localparam logic [NBR_W-1:0] NBR_CENTRE = 4'd0;
    localparam logic [NBR_W-1:0] NBR_LAST   = 4'd8;
    localparam int               CRD_S_W    = 10;

    // arithmetic, weights held in ten-thousandths
    localparam int WEIGHT_W    = 14;
    localparam int CENTRE_BASE = 9920;
    localparam int MISS_SHIFT  = 3;
    localparam int MISS_W      = 4;
    localparam int NSUM_W      = FL_W + 3;
    localparam int PROD_W      = WEIGHT_W + FL_W;
    localparam int NUM_W       = PROD_W + 1;
    localparam int DIV_CONST   = 10000;
    localparam int REM_W       = 14;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_CYCLES  = FL_W / DIV_STEPS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             clear_step;
        logic             map_wr;
        logic             fl_wr;
        logic             acc_clr;
        logic             issue;
        logic [NBR_W-1:0] nbr;
        logic             mul;
        logic             sum;
        logic             div_start;
        logic             out_load;
    } bmsm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              clear_last;
        logic              pipe_busy;
        logic              centre_ok;
        logic              div_done;
        logic              out_free;
    } bmsm_stat_t;

    // column offset of walk position k
    function automatic logic signed [1:0] nbr_dx(input logic [NBR_W-1:0] k);
        logic signed [1:0] d;
        case (k)
            4'd1, 4'd4, 4'd6: d = 2'sb11;
            4'd3, 4'd5, 4'd8: d = 2'sb01;
            default:          d = 2'sb00;
        endcase
        return d;
    endfunction

    // row offset of walk position k
    function automatic logic signed [1:0] nbr_dy(input logic [NBR_W-1:0] k);
        logic signed [1:0] d;
        case (k)
            4'd1, 4'd2, 4'd3: d = 2'sb11;
            4'd6, 4'd7, 4'd8: d = 2'sb01;
            default:          d = 2'sb00;
        endcase
        return d;
    endfunction

endpackage

// ----- hdl/beamlet_map_smoothing_unit.sv -----
// beamlet_map_smoothing_unit: top level, stream ports, configuration port
// depends on bmsm_pkg, bmsm_ctrl and bmsm_dp

// After reset the unit sweeps the cell map to empty, one cell per cycle
// (MAX_BEAMS * MAP_W * MAP_H cells, 8192 with the defaults); no item is taken
// during the sweep, while beamlet_count writes are taken at any time. Items are
// handled one at a time. A smooth item makes nine reads in turn through the
// single-port cell map and fluence memories (centre plus eight neighbours,
// overlapped as a three-stage read pipeline), then a divide by 10000 at four
// quotient bits per cycle, and waits until the result register is free. A
// finished result waits in the output register while the next item is
// accepted; a smooth item with an empty or invalid centre gives no transfer on
// the output.

module beamlet_map_smoothing_unit
    import bmsm_pkg::*;
#(
    parameter int MAP_W        = MAP_W_DEF,
    parameter int MAP_H        = MAP_H_DEF,
    parameter int MAX_BEAMS    = MAX_BEAMS_DEF,
    parameter int MAX_BEAMLETS = MAX_BEAMLETS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // beamlet_count write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [BCNT_W-1:0]     cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // beam, cell_x, cell_y, beamlet, fluence_in
    input  logic [IN_USER_W-1:0]  s_tuser,   // func
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // beamlet_out, smoothed
    output logic [OUT_USER_W-1:0] m_tuser    // saturated
);

    localparam int X_LO  = BEAM_W;
    localparam int Y_LO  = X_LO + COORD_W;
    localparam int BL_LO = Y_LO + COORD_W;
    localparam int FL_LO = BL_LO + ENTRY_W;
    localparam int PAD_W = OUT_DATA_W - BL_OUT_W - FL_W;

    bmsm_cmd_t           cmd;
    bmsm_stat_t          stat;
    logic [BL_OUT_W-1:0] out_beamlet;
    logic [FL_W-1:0]     out_smoothed;
    logic                out_sat;

    assign cfg_ready = 1'b1;

    bmsm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bmsm_dp #(
        .MAP_W        (MAP_W),
        .MAP_H        (MAP_H),
        .MAX_BEAMS    (MAX_BEAMS),
        .MAX_BEAMLETS (MAX_BEAMLETS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .in_func      (s_tuser[FUNC_W-1:0]),
        .in_beam      (s_tdata[X_LO-1:0]),
        .in_x         (s_tdata[Y_LO-1:X_LO]),
        .in_y         (s_tdata[BL_LO-1:Y_LO]),
        .in_beamlet   (s_tdata[FL_LO-1:BL_LO]),
        .in_fluence   (s_tdata[FL_LO+FL_W-1:FL_LO]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_beamlet  (out_beamlet),
        .out_smoothed (out_smoothed),
        .out_sat      (out_sat)
    );

    // result packing
    assign m_tdata = {{PAD_W{1'b0}}, out_smoothed, out_beamlet};
    assign m_tuser = out_sat;

    // a result is only produced for a valid centre cell
    a_result_needs_centre: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.centre_ok)
        else $error("result loaded without a valid centre cell");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten while held");

    // multiply only after the neighbour read pipeline has drained
    a_mul_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> !stat.pipe_busy)
        else $error("multiply started with reads in flight");

    // no item is taken during the map clear sweep
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !s_tready)
        else $error("input ready during map clear");

endmodule

// ----- hdl/bmsm_div.sv -----
// bmsm_div: restoring divide of the smoothing numerator by 10000, four
// quotient bits per cycle, with overflow detect; depends on bmsm_pkg

module bmsm_div
    import bmsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    output logic             done,
    output logic [FL_W-1:0]  quot,
    output logic             sat
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_next;
    logic [FL_W-1:0]      quo_reg;
    logic [FL_W-1:0]      quo_next;
    logic                 sat_reg;
    logic [NUM_W-FL_W-1:0] num_hi;

    assign num_hi = num[NUM_W-1:FL_W];

    // four shift/compare/subtract steps
    always_comb
    begin
        logic [REM_W:0]   t;
        logic [REM_W-1:0] r;
        logic [FL_W-1:0]  q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            t = {r, q[FL_W-1]};
            q = {q[FL_W-2:0], 1'b0};
            if (t >= (REM_W+1)'(DIV_CONST))
            begin
                t    = t - (REM_W+1)'(DIV_CONST);
                q[0] = 1'b1;
            end
            r = t[REM_W-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sat_reg <= (num_hi >= (NUM_W-FL_W)'(DIV_CONST));
            rem_reg <= num_hi[REM_W-1:0];
            quo_reg <= num[FL_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign sat  = sat_reg;

endmodule

// ----- hdl/bmsm_dp.sv -----
// bmsm_dp: datapath with item registers, cell map and fluence memories,
// neighbour read pipeline, accumulators, multiply, divider and output register
// depends on bmsm_pkg and bmsm_div

module bmsm_dp
    import bmsm_pkg::*;
#(
    parameter int MAP_W        = MAP_W_DEF,
    parameter int MAP_H        = MAP_H_DEF,
    parameter int MAX_BEAMS    = MAX_BEAMS_DEF,
    parameter int MAX_BEAMLETS = MAX_BEAMLETS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bmsm_cmd_t           cmd,
    output bmsm_stat_t          stat,
    input  logic                cfg_valid,
    input  logic [BCNT_W-1:0]   cfg_data,
    input  logic [FUNC_W-1:0]   in_func,
    input  logic [BEAM_W-1:0]   in_beam,
    input  logic [COORD_W-1:0]  in_x,
    input  logic [COORD_W-1:0]  in_y,
    input  logic [ENTRY_W-1:0]  in_beamlet,
    input  logic [FL_W-1:0]     in_fluence,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [BL_OUT_W-1:0] out_beamlet,
    output logic [FL_W-1:0]     out_smoothed,
    output logic                out_sat
);

    localparam int CELLS     = MAP_W * MAP_H;
    localparam int MAP_DEPTH = MAX_BEAMS * CELLS;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int FL_AW     = $clog2(MAX_BEAMLETS);

    // memories
    logic [ENTRY_W-1:0] map_mem [MAP_DEPTH];
    logic [FL_W-1:0]    fl_mem  [MAX_BEAMLETS];

    // item and configuration
    logic [FUNC_W-1:0]  func_reg;
    logic [BEAM_W-1:0]  beam_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [ENTRY_W-1:0] bl_reg;
    logic [FL_W-1:0]    fin_reg;
    logic [BCNT_W-1:0]  bcnt_reg;
    logic [MAP_AW-1:0]  clr_cnt_reg;

    // addressing
    logic [NBR_W-1:0]          nbr_sel;
    logic signed [CRD_S_W-1:0] nx;
    logic signed [CRD_S_W-1:0] ny;
    logic                      in_map;
    logic [31:0]               lin;
    logic [MAP_AW-1:0]         cell_addr;
    logic                      map_we;
    logic                      map_re;
    logic [MAP_AW-1:0]         map_addr;
    logic [ENTRY_W-1:0]        map_wdata;
    logic [ENTRY_W-1:0]        map_q;
    logic                      entry_ok;
    logic                      bl_ok;
    logic                      fl_we;
    logic                      fl_re;
    logic [FL_AW-1:0]          fl_addr;
    logic [FL_W-1:0]           fl_q;

    // read pipeline
    logic a_v_reg, a_in_reg, a_ctr_reg;
    logic b_v_reg, b_hit_reg, b_ctr_reg;
    logic centre_ok_reg;
    logic [BL_OUT_W-1:0] centre_bl_reg;
    logic [FL_W-1:0]     centre_fl_reg;
    logic [NSUM_W-1:0]   nsum_reg;
    logic [MISS_W-1:0]   miss_reg;

    // arithmetic
    logic [WEIGHT_W-1:0] weight;
    logic [PROD_W-1:0]   prod_reg;
    logic [NUM_W-1:0]    nsum10_reg;
    logic [NUM_W-1:0]    num_reg;
    logic                div_done;
    logic [FL_W-1:0]     div_quot;
    logic                div_sat;

    // output register
    logic                out_valid_reg;
    logic [BL_OUT_W-1:0] out_bl_reg;
    logic [FL_W-1:0]     out_sm_reg;
    logic                out_sat_reg;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            beam_reg <= in_beam;
            x_reg    <= in_x;
            y_reg    <= in_y;
            bl_reg   <= in_beamlet;
            fin_reg  <= in_fluence;
        end
    end

    // beamlet count register and clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                bcnt_reg <= cfg_data;
            if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // cell address of the item cell or of a walk position
    always_comb
    begin
        nbr_sel   = cmd.issue ? cmd.nbr : NBR_CENTRE;
        nx        = $signed(CRD_S_W'(x_reg)) + CRD_S_W'(nbr_dx(nbr_sel));
        ny        = $signed(CRD_S_W'(y_reg)) + CRD_S_W'(nbr_dy(nbr_sel));
        in_map    = (32'(beam_reg) < MAX_BEAMS) && (nx >= 0) && (ny >= 0) &&
                    (int'(nx) < MAP_W) && (int'(ny) < MAP_H);
        lin       = 32'(beam_reg) * 32'(CELLS) + 32'(unsigned'(ny)) * 32'(MAP_W) +
                    32'(unsigned'(nx));
        cell_addr = lin[MAP_AW-1:0];
    end

    // cell map port
    assign map_we    = cmd.clear_step || (cmd.map_wr && in_map);
    assign map_re    = cmd.issue && in_map;
    assign map_addr  = cmd.clear_step ? clr_cnt_reg : cell_addr;
    assign map_wdata = cmd.clear_step ? '1 : bl_reg;

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_addr] <= map_wdata;
        else if (map_re)
            map_q <= map_mem[map_addr];
    end

    // entry validity against the beamlet count and store depth
    assign entry_ok = a_in_reg && !map_q[ENTRY_W-1] && (map_q < bcnt_reg) &&
                      (32'(map_q) < MAX_BEAMLETS);
    assign bl_ok    = !bl_reg[ENTRY_W-1] && (32'(bl_reg) < MAX_BEAMLETS);

    // fluence store port
    assign fl_we   = cmd.fl_wr && bl_ok;
    assign fl_re   = a_v_reg && entry_ok;
    assign fl_addr = cmd.fl_wr ? FL_AW'(bl_reg) : FL_AW'(map_q);

    always_ff @(posedge clk)
    begin
        if (fl_we)
            fl_mem[fl_addr] <= fin_reg;
        else if (fl_re)
            fl_q <= fl_mem[fl_addr];
    end

    // pipeline control: map read, entry check, fluence read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg       <= 1'b0;
            a_in_reg      <= 1'b0;
            a_ctr_reg     <= 1'b0;
            b_v_reg       <= 1'b0;
            b_hit_reg     <= 1'b0;
            b_ctr_reg     <= 1'b0;
            centre_ok_reg <= 1'b0;
        end
        else
        begin
            a_v_reg   <= cmd.issue;
            a_in_reg  <= in_map;
            a_ctr_reg <= (nbr_sel == NBR_CENTRE);
            b_v_reg   <= a_v_reg;
            b_hit_reg <= entry_ok;
            b_ctr_reg <= a_ctr_reg;
            if (a_v_reg && a_ctr_reg)
                centre_ok_reg <= entry_ok;
        end
    end

    // centre capture and neighbour accumulation
    always_ff @(posedge clk)
    begin
        if (a_v_reg && a_ctr_reg)
            centre_bl_reg <= map_q[BL_OUT_W-1:0];
        if (cmd.acc_clr)
        begin
            nsum_reg <= '0;
            miss_reg <= '0;
        end
        else if (b_v_reg)
        begin
            if (b_ctr_reg)
                centre_fl_reg <= fl_q;
            else if (b_hit_reg)
                nsum_reg <= nsum_reg + NSUM_W'(fl_q);
            else
                miss_reg <= miss_reg + 1'b1;
        end
    end

    // weighted centre product and tenfold neighbour sum, then numerator
    assign weight = WEIGHT_W'(CENTRE_BASE) + (WEIGHT_W'(miss_reg) << MISS_SHIFT);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg   <= PROD_W'(weight) * PROD_W'(centre_fl_reg);
            nsum10_reg <= (NUM_W'(nsum_reg) << 3) + (NUM_W'(nsum_reg) << 1);
        end
        if (cmd.sum)
            num_reg <= NUM_W'(prod_reg) + nsum10_reg;
    end

    bmsm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .done  (div_done),
        .quot  (div_quot),
        .sat   (div_sat)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_bl_reg  <= centre_bl_reg;
            out_sm_reg  <= div_sat ? '1 : div_quot;
            out_sat_reg <= div_sat;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_beamlet  = out_bl_reg;
    assign out_smoothed = out_sm_reg;
    assign out_sat      = out_sat_reg;

    // status
    assign stat.func       = func_reg;
    assign stat.clear_last = (clr_cnt_reg == MAP_AW'(MAP_DEPTH - 1));
    assign stat.pipe_busy  = a_v_reg || b_v_reg;
    assign stat.centre_ok  = centre_ok_reg;
    assign stat.div_done   = div_done;
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

// ----- hdl/bmsm_ctrl.sv -----
// bmsm_ctrl: state machine sequencing map clear, load items and the smooth
// walk, multiply, divide and result hand-off; depends on bmsm_pkg

module bmsm_ctrl
    import bmsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  bmsm_stat_t stat,
    output bmsm_cmd_t  cmd
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DISPATCH = 4'd2;
    localparam logic [3:0] ST_ISSUE    = 4'd3;
    localparam logic [3:0] ST_DRAIN    = 4'd4;
    localparam logic [3:0] ST_MUL      = 4'd5;
    localparam logic [3:0] ST_SUM      = 4'd6;
    localparam logic [3:0] ST_DIV      = 4'd7;
    localparam logic [3:0] ST_DIVWAIT  = 4'd8;
    localparam logic [3:0] ST_OUT      = 4'd9;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [NBR_W-1:0] k_reg;
    logic [NBR_W-1:0] k_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.nbr    = k_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_IDLE;
                case (stat.func)
                    FUNC_MAP_WR: cmd.map_wr = 1'b1;
                    FUNC_FL_WR:  cmd.fl_wr  = 1'b1;
                    FUNC_SMOOTH:
                    begin
                        cmd.acc_clr = 1'b1;
                        k_next      = NBR_CENTRE;
                        state_next  = ST_ISSUE;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (k_reg == NBR_LAST)
                    state_next = ST_DRAIN;
                else
                    k_next = k_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = stat.centre_ok ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVWAIT;
            end
            ST_DIVWAIT:
            begin
                if (stat.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ----- dv/smoothing_checker.sv -----
`timescale 1ns / 1ps
// smoothing_checker: watches the beamlet_count, item and result streams of the
// beamlet map smoothing unit, predicts each smoothed result and compares fields
// depends on bmsm_pkg

module smoothing_checker
    import bmsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [BCNT_W-1:0]     cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // beam, cell_x, cell_y, beamlet, fluence_in
    input  logic [IN_USER_W-1:0]  s_tuser,   // func
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // beamlet_out, smoothed
    input  logic [OUT_USER_W-1:0] m_tuser,   // saturated
    output int                    results_pending,
    output int                    fail_count
);

    localparam int CELLS_PER_BEAM = MAP_W_DEF * MAP_H_DEF;
    localparam int MAP_CELLS      = MAX_BEAMS_DEF * CELLS_PER_BEAM;

    // item field positions in tdata, lowest first
    localparam int X_LSB   = BEAM_W;
    localparam int Y_LSB   = X_LSB + COORD_W;
    localparam int BL_LSB  = Y_LSB + COORD_W;
    localparam int FL_LSB  = BL_LSB + ENTRY_W;
    localparam int SM_LSB  = BL_OUT_W;

    typedef struct {
        logic [BL_OUT_W-1:0] beamlet;
        logic [FL_W-1:0]     smoothed;
        logic                saturated;
    } smooth_result_t;

    logic [ENTRY_W-1:0] map_shadow [MAP_CELLS];
    logic [FL_W-1:0]    fluence_shadow [MAX_BEAMLETS_DEF];
    logic [BCNT_W-1:0]  count_shadow;
    smooth_result_t     smoothed_due [$];

    smooth_result_t     got_res;
    smooth_result_t     want_res;
    logic [FUNC_W-1:0]  item_func;
    logic [BEAM_W-1:0]  item_beam;
    logic [COORD_W-1:0] item_x;
    logic [COORD_W-1:0] item_y;
    logic [ENTRY_W-1:0] item_bl;
    logic [FL_W-1:0]    item_fl;
    int                 idx;

    function automatic int cell_addr(input int beam, input int x, input int y);
        return beam * CELLS_PER_BEAM + y * MAP_W_DEF + x;
    endfunction

    // an entry names a beamlet only when non-negative and below the count
    function automatic bit entry_live(input logic [ENTRY_W-1:0] e);
        return !e[ENTRY_W-1] && (e < count_shadow);
    endfunction

    // weights in ten-thousandths: 10 * neighbour sum + (9920 + 8 * missing) * centre
    function automatic bit smooth_cell(input int beam, input int x, input int y,
                                       output smooth_result_t res);
        logic [ENTRY_W-1:0] centre;
        logic [ENTRY_W-1:0] nbr;
        logic [63:0]        nbr_sum;
        logic [63:0]        numer;
        logic [63:0]        quot;
        int                 missing;
        int                 nx;
        int                 ny;
        int                 dx;
        int                 dy;
        res.beamlet   = '0;
        res.smoothed  = '0;
        res.saturated = 1'b0;
        centre = map_shadow[cell_addr(beam, x, y)];
        if (!entry_live(centre))
            return 1'b0;
        nbr_sum = '0;
        missing = 0;
        for (dy = -1; dy <= 1; dy++)
        begin
            for (dx = -1; dx <= 1; dx++)
            begin
                if (dx == 0 && dy == 0)
                    continue;
                nx = x + dx;
                ny = y + dy;
                if (nx < 0 || ny < 0 || nx >= MAP_W_DEF || ny >= MAP_H_DEF)
                begin
                    missing++;
                end
                else
                begin
                    nbr = map_shadow[cell_addr(beam, nx, ny)];
                    if (entry_live(nbr))
                        nbr_sum += 64'(fluence_shadow[nbr[BL_OUT_W-1:0]]);
                    else
                        missing++;
                end
            end
        end
        numer = 64'd10 * nbr_sum
              + 64'(CENTRE_BASE + 8 * missing) * 64'(fluence_shadow[centre[BL_OUT_W-1:0]]);
        quot = numer / 64'(DIV_CONST);
        res.beamlet = centre[BL_OUT_W-1:0];
        if (quot > 64'hFFFF_FFFF)
        begin
            res.smoothed  = '1;
            res.saturated = 1'b1;
        end
        else
        begin
            res.smoothed  = quot[FL_W-1:0];
            res.saturated = 1'b0;
        end
        return 1'b1;
    endfunction

    // shadow state, prediction at item transfer, compare at result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (idx = 0; idx < MAP_CELLS; idx++)
                map_shadow[idx] = '1;
            for (idx = 0; idx < MAX_BEAMLETS_DEF; idx++)
                fluence_shadow[idx] = '0;
            count_shadow = '0;
            smoothed_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                count_shadow = cfg_data;

            if (m_tvalid && m_tready)
            begin
                got_res.beamlet   = m_tdata[BL_OUT_W-1:0];
                got_res.smoothed  = m_tdata[SM_LSB +: FL_W];
                got_res.saturated = m_tuser[0];
                if (smoothed_due.size() == 0)
                begin
                    $error("result with no smooth item waiting: beamlet_out %0d smoothed %h",
                           got_res.beamlet, got_res.smoothed);
                    fail_count++;
                end
                else
                begin
                    want_res = smoothed_due.pop_front();
                    if (got_res.beamlet !== want_res.beamlet)
                    begin
                        $error("beamlet_out: expected %0d, actual %0d",
                               want_res.beamlet, got_res.beamlet);
                        fail_count++;
                    end
                    if (got_res.smoothed !== want_res.smoothed)
                    begin
                        $error("smoothed: expected %h, actual %h",
                               want_res.smoothed, got_res.smoothed);
                        fail_count++;
                    end
                    if (got_res.saturated !== want_res.saturated)
                    begin
                        $error("saturated: expected %0b, actual %0b",
                               want_res.saturated, got_res.saturated);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                item_func = s_tuser;
                item_beam = s_tdata[BEAM_W-1:0];
                item_x    = s_tdata[X_LSB +: COORD_W];
                item_y    = s_tdata[Y_LSB +: COORD_W];
                item_bl   = s_tdata[BL_LSB +: ENTRY_W];
                item_fl   = s_tdata[FL_LSB +: FL_W];
                case (item_func)
                    FUNC_MAP_WR:
                        map_shadow[cell_addr(int'(item_beam), int'(item_x),
                                             int'(item_y))] = item_bl;
                    FUNC_FL_WR:
                        if (!item_bl[ENTRY_W-1])
                            fluence_shadow[item_bl[BL_OUT_W-1:0]] = item_fl;
                    FUNC_SMOOTH:
                        if (smooth_cell(int'(item_beam), int'(item_x), int'(item_y),
                                        want_res))
                            smoothed_due.push_back(want_res);
                    default:
                        ;
                endcase
            end
        end
        results_pending = smoothed_due.size();
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: clock, reset and stimulus for beamlet_map_smoothing_unit, final verdict
// depends on bmsm_pkg, beamlet_map_smoothing_unit and smoothing_checker

module tb_top;
    import bmsm_pkg::*;

    localparam logic [FUNC_W-1:0]  FUNC_UNUSED     = 2'd3;
    localparam logic [ENTRY_W-1:0] EMPTY_CELL      = '1;
    localparam int                 CLK_HALF        = 10;
    localparam int                 RESET_CYCLES    = 12;
    localparam int                 SETTLE_CYCLES   = 64;
    localparam int                 HOLD_OFF_CYCLES = 400;
    localparam int                 ITEM_TARGET     = 400;
    localparam int                 NUM_PHASES      = 6;
    localparam int                 COORD_MAX       = MAP_W_DEF - 1;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [BCNT_W-1:0]     cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // beam, cell_x, cell_y, beamlet, fluence_in
    logic [IN_USER_W-1:0]  s_tuser;   // func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // beamlet_out, smoothed
    logic [OUT_USER_W-1:0] m_tuser;   // saturated

    int          fail_count;
    int          results_pending;
    int          items_sent;
    int          burst_left;
    bit          hold_off_req;
    int unsigned fl_addrs [$];
    bit          fl_known [MAX_BEAMLETS_DEF];

    beamlet_map_smoothing_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    smoothing_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .results_pending (results_pending),
        .fail_count      (fail_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit, covers the map sweep after reset many times over
    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: changing stall patterns, one long hold-off on request
    initial
    begin
        int             mode;
        int             mode_left;
        logic [7:0]     mask;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        mask      = '0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 80);
                    mask      = 8'($urandom);
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        m_tready <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                endcase
                mode_left--;
            end
        end
    end

    // one item transfer; bursts of random length with random gaps between them
    task automatic send_item(input logic [FUNC_W-1:0]  func,
                             input logic [BEAM_W-1:0]  beam,
                             input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y,
                             input logic [ENTRY_W-1:0] bl,
                             input logic [FL_W-1:0]    fl);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= IN_DATA_W'({fl, bl, y, x, beam});
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic fl_write(input logic [ENTRY_W-1:0] addr, input logic [FL_W-1:0] value);
        send_item(FUNC_FL_WR, BEAM_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  addr, value);
        // remember written words; only these may ever be named by a map cell
        if (!addr[ENTRY_W-1] && !fl_known[addr[BL_OUT_W-1:0]])
        begin
            fl_known[addr[BL_OUT_W-1:0]] = 1'b1;
            fl_addrs.push_back(32'(addr[BL_OUT_W-1:0]));
        end
    endtask

    task automatic map_write(input logic [BEAM_W-1:0] beam, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [ENTRY_W-1:0] value);
        send_item(FUNC_MAP_WR, beam, x, y, value, FL_W'($urandom));
    endtask

    task automatic smooth(input logic [BEAM_W-1:0] beam, input logic [COORD_W-1:0] x,
                          input logic [COORD_W-1:0] y);
        send_item(FUNC_SMOOTH, beam, x, y, ENTRY_W'($urandom), FL_W'($urandom));
    endtask

    // write beamlet_count once the unit has drained
    task automatic set_beamlet_count(input logic [BCNT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // map content: mostly written beamlets, else empty or other negatives
    function automatic logic [ENTRY_W-1:0] pick_entry();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return ENTRY_W'(fl_addrs[$urandom_range(0, fl_addrs.size() - 1)]);
        if (r < 18)
            return EMPTY_CELL;
        return {1'b1, BL_OUT_W'($urandom)};
    endfunction

    function automatic logic [FL_W-1:0] pick_fluence();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return FL_W'($urandom_range(0, 65535));
            default: return FL_W'($urandom);
        endcase
    endfunction

    // coordinates lean toward the map border
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return COORD_W'(COORD_MAX);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // fluence address: rewrite, fresh word, or negative and dropped
    function automatic logic [ENTRY_W-1:0] pick_fl_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return ENTRY_W'(fl_addrs[$urandom_range(0, fl_addrs.size() - 1)]);
        if (r < 9)
            return ENTRY_W'($urandom_range(0, MAX_BEAMLETS_DEF - 1));
        return {1'b1, BL_OUT_W'($urandom)};
    endfunction

    // fill a neighbourhood, maybe touch a fluence word, then smooth its centre
    task automatic smooth_cluster();
        logic [BEAM_W-1:0]  beam;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        int                 nx;
        int                 ny;
        int                 dx;
        int                 dy;
        beam = BEAM_W'($urandom);
        cx   = pick_coord();
        cy   = pick_coord();
        map_write(beam, cx, cy, pick_entry());
        if ($urandom_range(0, 3) == 0)
        begin
            for (dy = -1; dy <= 1; dy++)
            begin
                for (dx = -1; dx <= 1; dx++)
                begin
                    nx = int'(cx) + dx;
                    ny = int'(cy) + dy;
                    if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0
                        && nx <= COORD_MAX && ny <= COORD_MAX)
                        map_write(beam, COORD_W'(nx), COORD_W'(ny), pick_entry());
                end
            end
        end
        else
        begin
            repeat ($urandom_range(0, 5))
            begin
                nx = int'(cx) + int'($urandom_range(0, 2)) - 1;
                ny = int'(cy) + int'($urandom_range(0, 2)) - 1;
                if (nx >= 0 && ny >= 0 && nx <= COORD_MAX && ny <= COORD_MAX)
                    map_write(beam, COORD_W'(nx), COORD_W'(ny), pick_entry());
            end
        end
        if ($urandom_range(0, 3) == 0)
            fl_write(pick_fl_addr(), pick_fluence());
        smooth(beam, cx, cy);
    endtask

    // single unrelated items
    task automatic random_noise();
        case ($urandom_range(0, 3))
            0: send_item(FUNC_UNUSED, BEAM_W'($urandom), COORD_W'($urandom),
                         COORD_W'($urandom), ENTRY_W'($urandom), FL_W'($urandom));
            1: smooth(BEAM_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            2: map_write(BEAM_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                         pick_entry());
            default: fl_write(pick_fl_addr(), pick_fluence());
        endcase
    endtask

    // stimulus and verdict
    initial
    begin
        logic [BCNT_W-1:0] phase_count [NUM_PHASES];
        int                ph;
        int                phase_end;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        items_sent   = 0;
        burst_left   = 0;
        hold_off_req = 1'b0;
        phase_count  = '{13'd4096, 13'd1, 13'd2048, 13'd4095, 13'd0, 13'd0};
        phase_count[NUM_PHASES-1] = BCNT_W'($urandom_range(2, 4096));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_beamlet_count(13'd0);

        // directed: field extremes, corners, every func, the no-result cases
        fl_write(13'd0, 32'hFFFF_FFFF);
        fl_write(13'd4095, 32'hFFFF_FFFF);
        fl_write(13'd1, 32'h0001_0000);
        fl_write(13'd2, 32'h0000_0000);
        fl_write(EMPTY_CELL, 32'h1234_5678);            // negative address, dropped
        map_write(3'd0, 5'd0, 5'd0, 13'd0);
        map_write(3'd0, 5'd1, 5'd0, 13'd4095);
        map_write(3'd0, 5'd0, 5'd1, 13'd1);
        map_write(3'd0, 5'd1, 5'd1, 13'd0);
        smooth(3'd0, 5'd0, 5'd0);                        // count zero, centre not live
        set_beamlet_count(13'd4096);
        smooth(3'd0, 5'd0, 5'd0);                        // corner, near full scale, not saturated
        map_write(3'd7, 5'd31, 5'd31, 13'd1);
        smooth(3'd7, 5'd31, 5'd31);                      // all neighbours missing
        map_write(3'd7, 5'd30, 5'd30, 13'd2);
        smooth(3'd7, 5'd31, 5'd31);                      // zero fluence neighbour
        map_write(3'd3, 5'd5, 5'd5, EMPTY_CELL);
        smooth(3'd3, 5'd5, 5'd5);                        // empty centre
        map_write(3'd3, 5'd6, 5'd6, 13'h1000);
        smooth(3'd3, 5'd6, 5'd6);                        // most negative entry
        smooth(3'd5, 5'd17, 5'd9);                       // never written cell
        send_item(FUNC_UNUSED, 3'd7, 5'd31, 5'd31, 13'd4095, 32'hFFFF_FFFF);

        // random phases, one per beamlet_count setting
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_beamlet_count(phase_count[ph]);
            if (ph == 0)
                hold_off_req = 1'b1;
            phase_end = items_sent + ITEM_TARGET / NUM_PHASES;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 4) != 0)
                    smooth_cluster();
                else
                    random_noise();
            end
        end

        // drain
        s_tvalid <= 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
